// ===== rtl/core/mma_pkg.sv =====
// Shared constants, payload words and controller/datapath command types.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  // Channel count and averaging window
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned WINDOW   = 64;

  // Derived widths
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned POS_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned ADDR_W  = $clog2(CHANNELS * WINDOW);
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned SUM_W   = SMP_W + $clog2(WINDOW);
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

  // Input word
  typedef struct packed {
    logic [7:0]               channel;
    logic signed [SMP_W-1:0]  sample;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [SMP_W-1:0]  average;
    logic                     bad_channel;
    logic                     error_seen;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted input word
    logic rd;        // read the oldest sample of the channel
    logic update;    // write sample, update channel state, load divider
    logic step;      // one quotient bit
    logic load_out;  // move the result into the output register
  } mma_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_bad;    // channel of the offered input word is out of range
    logic div_last;  // divider is on its final quotient bit
  } mma_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/multichannel_moving_average_unit.sv =====
// Top level of the multichannel moving average unit.
`timescale 1ns / 1ps
`default_nettype none

// Running mean over the last 64 signed 16-bit samples of each of 8 channels.
// Each input word names a channel and carries one sample; each produces exactly
// one output word with the mean (sum over fill count, truncated toward zero),
// a bad-channel bit and a sticky error bit. A channel number of 8 or more
// returns a mean of 0 and sets the sticky error. An accepted in-range word
// goes through a read of the oldest sample from the ring memory, the channel
// update, the bit-serial divider (one quotient bit per cycle over the 22-bit
// sum), the load of the result register once it is free, and the return to
// idle, where the unit is ready again. An out-of-range word skips straight to
// the result load. The result register lets the next word be accepted while a
// result waits to be taken. No clearing pass follows reset: a ring slot's read
// value is only used once its channel's fill count shows the slot was written.
module multichannel_moving_average_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mma_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mma_pkg::out_word_t      out_word_o
);
  import mma_pkg::*;

  mma_cmd_t cmd;
  mma_sts_t sts;

  // Sequencer
  mma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, arithmetic and result register
  mma_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mma_ctrl.sv =====
// Sequencing state machine for the moving average unit.
`timescale 1ns / 1ps
`default_nettype none

module mma_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mma_pkg::mma_sts_t sts_i,
  output mma_pkg::mma_cmd_t   cmd_o
);
  import mma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode commands and next state
  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o           = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.in_bad ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mma_dp.sv =====
// Datapath: sample ring memory, per-channel state, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module mma_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mma_pkg::in_word_t in_word_i,
  input  wire mma_pkg::mma_cmd_t cmd_i,
  output mma_pkg::mma_sts_t      sts_o,
  output mma_pkg::out_word_t     out_word_o
);
  import mma_pkg::*;

  // Sample ring memory, no reset: a slot's read value is used only once its channel is full
  logic signed [SMP_W-1:0] mem_q [CHANNELS*WINDOW];

  // Per-channel state
  logic [POS_W-1:0]        pos_q [CHANNELS];
  logic [CNT_W-1:0]        cnt_q [CHANNELS];
  logic signed [SUM_W-1:0] sum_q [CHANNELS];

  // Item registers
  logic [CH_W-1:0]         ch_q;
  logic signed [SMP_W-1:0] smp_q;
  logic                    bad_q;
  logic                    err_q;
  logic signed [SMP_W-1:0] old_q;

  // Divider registers
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W-1:0]        dvs_q;
  logic [STEP_W-1:0]       step_q;
  logic                    neg_q;

  out_word_t               out_q;

  logic [ADDR_W-1:0]       addr;
  logic                    full;
  logic [CNT_W-1:0]        cnt_new;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        mag_new;
  logic [CNT_W:0]          trial;
  logic                    fits;
  logic [SUM_W-1:0]        quo_signed;

  assign sts_o.in_bad   = (in_word_i.channel >= 8'(CHANNELS));
  assign sts_o.div_last = (step_q == STEP_W'(SUM_W - 1));
  assign out_word_o     = out_q;

  // Slot of the current write position
  assign addr = ADDR_W'(ADDR_W'(ch_q) * ADDR_W'(WINDOW)) + ADDR_W'(pos_q[ch_q]);

  // New running sum and fill count
  always_comb begin
    full    = (cnt_q[ch_q] == CNT_W'(WINDOW));
    cnt_new = full ? cnt_q[ch_q] : cnt_q[ch_q] + CNT_W'(1);
    if (full) begin
      sum_new = sum_q[ch_q] - SUM_W'(old_q) + SUM_W'(smp_q);
    end else begin
      sum_new = sum_q[ch_q] + SUM_W'(smp_q);
    end
    mag_new = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
  end

  // One restoring division step
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
  end

  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  // Ring memory write and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      old_q <= mem_q[addr];
    end
    if (cmd_i.update) begin
      mem_q[addr] <= smp_q;
    end
  end

  // Per-channel state and sticky error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i] <= '0;
        cnt_q[i] <= '0;
        sum_q[i] <= '0;
      end
      err_q <= 1'b0;
    end else begin
      if (cmd_i.capture && sts_o.in_bad) begin
        err_q <= 1'b1;
      end
      if (cmd_i.update) begin
        pos_q[ch_q] <= (pos_q[ch_q] == POS_W'(WINDOW - 1)) ? '0
                                                           : pos_q[ch_q] + POS_W'(1);
        cnt_q[ch_q] <= cnt_new;
        sum_q[ch_q] <= sum_new;
      end
    end
  end

  // Item capture, divider and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q  <= in_word_i.channel[CH_W-1:0];
      smp_q <= in_word_i.sample;
      bad_q <= sts_o.in_bad;
    end
    if (cmd_i.update) begin
      quo_q  <= mag_new;
      neg_q  <= sum_new[SUM_W-1];
      dvs_q  <= cnt_new;
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.step) begin
      rem_q  <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_q  <= {quo_q[SUM_W-2:0], fits};
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.load_out) begin
      out_q.average     <= bad_q ? '0 : quo_signed[SMP_W-1:0];
      out_q.bad_channel <= bad_q;
      out_q.error_seen  <= err_q;
    end
  end

endmodule

`default_nettype wire
